[hw/rtl/wsu_pkg.sv]
// Shared types and constants for the WebSocket frame unmask/echo block.
package wsu_pkg;

    // Frame stream constants
    localparam logic [7:0] WSU_TOP_BIT      = 8'd128;
    localparam logic [7:0] WSU_REPLY_OPCODE = 8'd129;
    localparam logic [6:0] WSU_FIRST_EXT    = 7'd126;
    localparam int         WSU_MASK_LEN     = 4;
    localparam int         WSU_QUEUE_DEPTH  = 4;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_HDR  = 2'd0,
        KIND_DATA = 2'd1,
        KIND_END  = 2'd2,
        KIND_ERR  = 2'd3
    } t_kind;

    // Parser phase; closed session is a phase of its own
    typedef enum logic [2:0] {
        PH_HDR0   = 3'd0,
        PH_LEN    = 3'd1,
        PH_MASK   = 3'd2,
        PH_DATA   = 3'd3,
        PH_CLOSED = 3'd4
    } t_phase;

    // Command from front to back; a header command expands to two results
    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
        logic       last;
    } t_cmd;

endpackage

[hw/rtl/websocket_frame_unmask_echo_top.sv]
// Top level: WebSocket frame unmasker and echo framer.
// A byte's result is written into the queue when the byte is accepted and is shown from the queue head.
// Throughput: one input byte per cycle while the queue is not full; one result per cycle
// leaves the queue while pop is held, a header byte yields two results and is absorbed by the four mask bytes after it.
// Reset (synchronous, active low) clears phase, mask key, counters and the queue.
module websocket_frame_unmask_echo_top
    import wsu_pkg::*;
#(
    parameter int QUEUE_DEPTH = WSU_QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_in_byte,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_out_byte,
    output logic [1:0] o_out_kind,
    output logic       o_frame_last
);

    logic accept;
    logic cmd_valid;
    t_cmd cmd;
    logic head_valid;
    t_cmd head;
    logic deq;

    assign accept = push && !full;

    // Parse incoming bytes
    wsu_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_in_byte   (i_in_byte),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd)
    );

    // Decouple parser from result consumer
    wsu_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (cmd_valid),
        .i_wr_cmd (cmd),
        .i_rd     (deq),
        .o_full   (full),
        .o_valid  (head_valid),
        .o_head   (head)
    );

    // Expand commands into results
    wsu_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head),
        .i_pop        (pop),
        .o_deq        (deq),
        .o_empty      (empty),
        .o_out_byte   (o_out_byte),
        .o_out_kind   (o_out_kind),
        .o_frame_last (o_frame_last)
    );

endmodule

[hw/rtl/wsu_front.sv]
// Front end: parses the received frame stream and issues reply commands.
module wsu_front
    import wsu_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_in_byte,
    output logic       o_cmd_valid,
    output t_cmd       o_cmd
);

    localparam int PosW = $clog2(WSU_MASK_LEN);

    t_phase          r_phase, n_phase;
    logic [6:0]      r_remaining, n_remaining;
    logic [PosW-1:0] r_pos, n_pos;
    logic [7:0]      r_mask [WSU_MASK_LEN];
    logic            mask_we;
    logic [6:0]      len;

    assign len = i_in_byte[6:0];

    // Hold phase, counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HDR0;
            r_remaining <= '0;
            r_pos       <= '0;
        end else begin
            r_phase     <= n_phase;
            r_remaining <= n_remaining;
            r_pos       <= n_pos;
        end
    end

    // Capture mask key bytes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < WSU_MASK_LEN; k++) r_mask[k] <= '0;
        end else if (mask_we) begin
            r_mask[r_pos] <= i_in_byte;
        end
    end

    // Advance phase and classify the byte
    always_comb begin
        n_phase     = r_phase;
        n_remaining = r_remaining;
        n_pos       = r_pos;
        mask_we     = 1'b0;
        o_cmd_valid = 1'b0;
        o_cmd       = '{kind: KIND_HDR, data: 8'd0, last: 1'b0};
        if (i_accept) begin
            unique case (r_phase)
                PH_HDR0: begin
                    n_phase = PH_LEN;
                end
                PH_LEN: begin
                    o_cmd_valid = 1'b1;
                    if (i_in_byte < WSU_TOP_BIT) begin
                        n_phase    = PH_CLOSED;
                        o_cmd.kind = KIND_END;
                    end else if (len >= WSU_FIRST_EXT) begin
                        n_phase    = PH_CLOSED;
                        o_cmd.kind = KIND_ERR;
                    end else begin
                        n_phase     = PH_MASK;
                        n_remaining = len;
                        n_pos       = '0;
                        o_cmd.kind  = KIND_HDR;
                        o_cmd.data  = {1'b0, len};
                        o_cmd.last  = (len == 7'd0);
                    end
                end
                PH_MASK: begin
                    mask_we = 1'b1;
                    n_pos   = r_pos + 1'b1;
                    if (r_pos == PosW'(WSU_MASK_LEN - 1))
                        n_phase = (r_remaining == 7'd0) ? PH_HDR0 : PH_DATA;
                end
                PH_DATA: begin
                    o_cmd_valid = 1'b1;
                    o_cmd.kind  = KIND_DATA;
                    o_cmd.data  = i_in_byte ^ r_mask[r_pos];
                    o_cmd.last  = (r_remaining == 7'd1);
                    n_remaining = r_remaining - 7'd1;
                    n_pos       = r_pos + 1'b1;
                    if (r_remaining == 7'd1) begin
                        n_pos   = '0;
                        n_phase = PH_HDR0;
                    end
                end
                PH_CLOSED: begin
                    n_phase = PH_CLOSED;
                end
                default: begin
                    n_phase = PH_HDR0;
                end
            endcase
        end
    end

endmodule

[hw/rtl/wsu_fifo.sv]
// Command queue between the parser front end and the result back end.
module wsu_fifo
    import wsu_pkg::*;
#(
    parameter int DEPTH = WSU_QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr,
    input  t_cmd i_wr_cmd,
    input  logic i_rd,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_head
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    t_cmd            r_mem [DEPTH];
    logic [PtrW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CntW-1:0] r_count;
    logic            do_wr, do_rd;

    assign o_full  = (r_count == CntW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign do_wr   = i_wr && !o_full;
    assign do_rd   = i_rd && o_valid;
    assign o_head  = r_mem[r_rd_ptr];

    // Store requests
    always_ff @(posedge i_clk) begin
        if (do_wr) r_mem[r_wr_ptr] <= i_wr_cmd;
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_wr)
                r_wr_ptr <= (r_wr_ptr == PtrW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            if (do_rd)
                r_rd_ptr <= (r_rd_ptr == PtrW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            if (do_wr && !do_rd)
                r_count <= r_count + 1'b1;
            else if (do_rd && !do_wr)
                r_count <= r_count - 1'b1;
        end
    end

endmodule

[hw/rtl/wsu_back.sv]
// Back end: expands queued commands into result requests.
module wsu_back
    import wsu_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_head_valid,
    input  t_cmd       i_head,
    input  logic       i_pop,
    output logic       o_deq,
    output logic       o_empty,
    output logic [7:0] o_out_byte,
    output logic [1:0] o_out_kind,
    output logic       o_frame_last
);

    logic r_second;
    logic opcode_slot;

    // Header command: opcode byte first, length byte second
    assign opcode_slot  = (i_head.kind == KIND_HDR) && !r_second;
    assign o_empty      = !i_head_valid;
    assign o_out_byte   = opcode_slot ? WSU_REPLY_OPCODE : i_head.data;
    assign o_out_kind   = i_head.kind;
    assign o_frame_last = opcode_slot ? 1'b0 : i_head.last;
    assign o_deq        = i_pop && i_head_valid && !opcode_slot;

    // Track which half of a header request is shown
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_second <= 1'b0;
        end else if (i_pop && i_head_valid) begin
            r_second <= opcode_slot;
        end
    end

endmodule
